/* sv/asfcu_pkg.sv */
// ----------------------------------------------------------------------------
// asfcu_pkg
// shared types and codes for the shifter, flag and condition unit
// ----------------------------------------------------------------------------
`default_nettype none

package asfcu_pkg;

	// operation select
	localparam logic [3:0] FUNC_COND = 4'd0;
	localparam logic [3:0] FUNC_LSL  = 4'd1;
	localparam logic [3:0] FUNC_LSR  = 4'd2;
	localparam logic [3:0] FUNC_ASR  = 4'd3;
	localparam logic [3:0] FUNC_ROR  = 4'd4;
	localparam logic [3:0] FUNC_NZ   = 4'd5;
	localparam logic [3:0] FUNC_NZC  = 4'd6;
	localparam logic [3:0] FUNC_ADD  = 4'd7;
	localparam logic [3:0] FUNC_ADC  = 4'd8;
	localparam logic [3:0] FUNC_SUB  = 4'd9;
	localparam logic [3:0] FUNC_SBC  = 4'd10;

	// condition field codes
	localparam logic [3:0] COND_EQ = 4'h0;
	localparam logic [3:0] COND_NE = 4'h1;
	localparam logic [3:0] COND_CS = 4'h2;
	localparam logic [3:0] COND_CC = 4'h3;
	localparam logic [3:0] COND_MI = 4'h4;
	localparam logic [3:0] COND_PL = 4'h5;
	localparam logic [3:0] COND_VS = 4'h6;
	localparam logic [3:0] COND_VC = 4'h7;
	localparam logic [3:0] COND_HI = 4'h8;
	localparam logic [3:0] COND_LS = 4'h9;
	localparam logic [3:0] COND_GE = 4'hA;
	localparam logic [3:0] COND_LT = 4'hB;
	localparam logic [3:0] COND_GT = 4'hC;
	localparam logic [3:0] COND_LE = 4'hD;
	localparam logic [3:0] COND_AL = 4'hE;

	localparam logic [7:0] SHIFT_WORD = 8'd32;

	typedef struct packed {
		logic [3:0]  func;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic        carry_in;
		logic [31:0] alu_result;
		logic [7:0]  shift_amount;
		logic        set_carry;
		logic        shifter_carry;
		logic [3:0]  cond_code;
	} req_t;

	typedef struct packed {
		logic [31:0] shifted_value;
		logic        cond_pass;
		logic        flag_n;
		logic        flag_z;
		logic        flag_c;
		logic        flag_v;
	} rsp_t;

	// nzcv in architectural bit order: n, z, c, v
	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} nzcv_t;

endpackage

`default_nettype wire

/* sv/arm_shifter_flags_condition_unit_top.sv */
// ----------------------------------------------------------------------------
// arm_shifter_flags_condition_unit_top
// barrel shifter, nzcv flag update and condition check with one flag register
// ----------------------------------------------------------------------------
// path: an accepted request is registered in the input stage, then its response in the output register
// throughput: one word per cycle unless rsp_ready stalls; the flag register is
//   written as the response loads, so the next word in the input stage sees it
// reset: arst_n clears the stage valids and all four flags at once
`default_nettype none

module arm_shifter_flags_condition_unit_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  asfcu_pkg::req_t     req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output asfcu_pkg::rsp_t     rsp
);
	import asfcu_pkg::*;

	// input stage
	logic  valid_s1;
	req_t  req_s1;

	// output stage
	logic  out_valid_q;
	rsp_t  out_q;

	// architectural flags
	nzcv_t flags_q;

	// computed for the word in the input stage
	nzcv_t flags_nxt;
	rsp_t  rsp_nxt;

	// output register takes a new word when empty or being drained
	logic  advance;
	assign advance   = !out_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	// ---------------------------------------------------------------- shifter
	logic [7:0]         amt;
	logic               amt_zero;
	logic               amt_le32;
	logic [5:0]         amt6;
	logic [5:0]         asr_amt;
	logic [32:0]        lsl_ext;
	logic [32:0]        lsr_ext;
	logic signed [32:0] asr_ext;
	logic [63:0]        ror_ext;
	logic [31:0]        sh_res;
	logic               sh_co;

	assign amt      = req_s1.shift_amount;
	assign amt_zero = (amt == 8'd0);
	assign amt_le32 = (amt <= SHIFT_WORD);
	assign amt6     = amt[5:0];
	// asr saturates at a full word: every bit becomes the sign
	assign asr_amt  = amt_le32 ? amt6 : SHIFT_WORD[5:0];

	// one extra bit on the exit side catches the last bit shifted out
	assign lsl_ext = {1'b0, req_s1.operand_a} << amt6;
	assign lsr_ext = {req_s1.operand_a, 1'b0} >> amt6;
	assign asr_ext = $signed({req_s1.operand_a, 1'b0}) >>> asr_amt;
	assign ror_ext = {req_s1.operand_a, req_s1.operand_a} >> amt[4:0];

	always_comb begin
		sh_res = req_s1.operand_a;
		sh_co  = 1'b0;
		case (req_s1.func)
			FUNC_LSL: begin
				sh_res = amt_le32 ? lsl_ext[31:0] : 32'd0;
				sh_co  = amt_le32 & lsl_ext[32];
			end
			FUNC_LSR: begin
				sh_res = amt_le32 ? lsr_ext[32:1] : 32'd0;
				sh_co  = amt_le32 & lsr_ext[0];
			end
			FUNC_ASR: begin
				sh_res = asr_ext[32:1];
				sh_co  = asr_ext[0];
			end
			FUNC_ROR: begin
				// multiple of 32 leaves the word as is, carry is bit 31 either way
				sh_res = ror_ext[31:0];
				sh_co  = ror_ext[31];
			end
			default: begin
				sh_res = req_s1.operand_a;
				sh_co  = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------ flag logic
	logic        res_n;
	logic        res_z;
	logic [32:0] adc_sum;
	logic [32:0] sbc_sum;
	logic        v_add;
	logic        v_sub;

	assign res_n   = req_s1.alu_result[31];
	assign res_z   = (req_s1.alu_result == 32'd0);
	assign adc_sum = {1'b0, req_s1.operand_a} + {1'b0, req_s1.operand_b}
		+ {32'd0, req_s1.carry_in};
	assign sbc_sum = {1'b0, req_s1.operand_a} + {1'b0, ~req_s1.operand_b}
		+ {32'd0, req_s1.carry_in};
	// overflow from operand and result signs
	assign v_add = ~(req_s1.operand_a[31] ^ req_s1.operand_b[31])
		& (req_s1.operand_a[31] ^ req_s1.alu_result[31]);
	assign v_sub = (req_s1.operand_a[31] ^ req_s1.operand_b[31])
		& (req_s1.operand_a[31] ^ req_s1.alu_result[31]);

	// ------------------------------------------------------- condition check
	logic cond_ok;

	always_comb begin
		case (req_s1.cond_code)
			COND_EQ: cond_ok = flags_q.z;
			COND_NE: cond_ok = !flags_q.z;
			COND_CS: cond_ok = flags_q.c;
			COND_CC: cond_ok = !flags_q.c;
			COND_MI: cond_ok = flags_q.n;
			COND_PL: cond_ok = !flags_q.n;
			COND_VS: cond_ok = flags_q.v;
			COND_VC: cond_ok = !flags_q.v;
			COND_HI: cond_ok = flags_q.c && !flags_q.z;
			COND_LS: cond_ok = !flags_q.c || flags_q.z;
			COND_GE: cond_ok = (flags_q.n == flags_q.v);
			COND_LT: cond_ok = (flags_q.n != flags_q.v);
			COND_GT: cond_ok = !flags_q.z && (flags_q.n == flags_q.v);
			COND_LE: cond_ok = flags_q.z || (flags_q.n != flags_q.v);
			COND_AL: cond_ok = 1'b1;
			default: cond_ok = 1'b0;	// nv never passes
		endcase
	end

	// --------------------------------------------------------- result select
	always_comb begin
		flags_nxt             = flags_q;
		rsp_nxt.shifted_value = 32'd0;
		rsp_nxt.cond_pass     = 1'b0;
		case (req_s1.func)
			FUNC_COND: begin
				rsp_nxt.cond_pass = cond_ok;
			end
			FUNC_LSL, FUNC_LSR, FUNC_ASR, FUNC_ROR: begin
				// zero amount passes the word through and leaves carry alone
				rsp_nxt.shifted_value = amt_zero ? req_s1.operand_a : sh_res;
				if (req_s1.set_carry && !amt_zero) begin
					flags_nxt.c = sh_co;
				end
			end
			FUNC_NZ: begin
				flags_nxt.n = res_n;
				flags_nxt.z = res_z;
			end
			FUNC_NZC: begin
				flags_nxt.n = res_n;
				flags_nxt.z = res_z;
				flags_nxt.c = req_s1.shifter_carry;
			end
			FUNC_ADD: begin
				flags_nxt = '{n: res_n, z: res_z,
					c: (req_s1.alu_result < req_s1.operand_a), v: v_add};
			end
			FUNC_ADC: begin
				flags_nxt = '{n: res_n, z: res_z, c: adc_sum[32], v: v_add};
			end
			FUNC_SUB: begin
				flags_nxt = '{n: res_n, z: res_z,
					c: (req_s1.operand_a >= req_s1.operand_b), v: v_sub};
			end
			FUNC_SBC: begin
				flags_nxt = '{n: res_n, z: res_z, c: sbc_sum[32], v: v_sub};
			end
			default: begin
				// unused codes: no flag change; shifted value and cond_pass are zero
				flags_nxt = flags_q;
			end
		endcase
		rsp_nxt.flag_n = flags_nxt.n;
		rsp_nxt.flag_z = flags_nxt.z;
		rsp_nxt.flag_c = flags_nxt.c;
		rsp_nxt.flag_v = flags_nxt.v;
	end

	// ------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					flags_q <= flags_nxt;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance && valid_s1) begin
			out_q <= rsp_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	// flags move only when a word is loaded into the output register
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(flags_q))
		else $error("flags changed without a word retiring");

	// the pending response always shows the current flags
	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.flag_n == flags_q.n && out_q.flag_z == flags_q.z
			&& out_q.flag_c == flags_q.c && out_q.flag_v == flags_q.v))
		else $error("response flags differ from flag register");

	// an empty output register never stalls the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> req_ready)
		else $error("request stalled with empty output register");
`endif

endmodule

`default_nettype wire
